@@ rtl/ms_pkg.sv @@
// ----------------------------------------------------------------------------
// ms_pkg
// Shared types and constants of the merge sorter: key type, default
// capacity and the memory control bundle between sequencer and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ms_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned CAPACITY_DEF = 64;

  typedef logic signed [KEY_W-1:0] key_t;

  // write strobe and bank selects issued by the sequencer
  typedef struct packed {
    logic we;
    logic wr_bank;
    logic rd_bank;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/ms_if.sv @@
// ----------------------------------------------------------------------------
// ms_if
// Valid/ready channels of the merge sorter: key input and sorted output.
// ----------------------------------------------------------------------------
`default_nettype none

interface ms_key_if;
  logic          valid;
  logic          ready;
  ms_pkg::key_t  key;
  logic          final_req;

  modport source (output valid, output key, output final_req, input ready);
  modport sink   (input valid, input key, input final_req, output ready);
endinterface

interface ms_sorted_if;
  logic          valid;
  logic          ready;
  ms_pkg::key_t  sorted_key;
  logic          end_of_run;

  modport source (output valid, output sorted_key, output end_of_run, input ready);
  modport sink   (input valid, input sorted_key, input end_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/ms_bank.sv @@
// ----------------------------------------------------------------------------
// ms_bank
// Key memory bank: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ms_bank #(
  parameter int unsigned DEPTH = ms_pkg::CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire ms_pkg::key_t             wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output ms_pkg::key_t                  rdata_a_o,
  output ms_pkg::key_t                  rdata_b_o
);
  import ms_pkg::*;

  key_t mem_q [DEPTH];
  key_t rdata_a_q;
  key_t rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

@@ rtl/ms_ctrl.sv @@
// ----------------------------------------------------------------------------
// ms_ctrl
// Sequencer of the merge sorter: loads keys, runs bottom-up merge passes
// through one shared compare unit between two ping-pong banks, then
// streams the sorted set out.
// ----------------------------------------------------------------------------
`default_nettype none

module ms_ctrl #(
  parameter int unsigned CAPACITY = ms_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ms_pkg::key_t                in_key_i,
  input  wire logic                        in_final_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             out_last_o,
  output ms_pkg::mem_ctl_t                 mem_ctl_o,
  output logic [$clog2(CAPACITY)-1:0]      waddr_o,
  output logic [$clog2(CAPACITY)-1:0]      raddr_a_o,
  output logic [$clog2(CAPACITY)-1:0]      raddr_b_o,
  output ms_pkg::key_t                     wdata_o,
  input  wire ms_pkg::key_t                rdata_a_i,
  input  wire ms_pkg::key_t                rdata_b_i
);
  import ms_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = CW + 2;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
  localparam logic [PW-1:0] ONE_P = PW'(1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_READ,
    ST_MERGE,
    ST_OUT_READ,
    ST_OUT_SHOW
  } state_e;

  state_e        state_q;
  logic [PW-1:0] cnt_q, w_q, lo_q, mid_q, hi_q, a_q, b_q, k_q, idx_q;
  logic          src_q;
  logic          out_valid_q;

  logic          accept;
  logic          room;
  logic [PW-1:0] cnt_inc;
  logic [PW-1:0] lo_w, lo_2w, mid_n, hi_n;
  logic          a_live, b_live, take_a;
  logic [PW-1:0] k_next, w_dbl;
  logic          run_done, pass_done, sort_done;

  // load side
  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign room       = (cnt_q < CAP_P);
  assign cnt_inc    = cnt_q + PW'(room);

  // run bounds, clipped to the set size
  assign w_dbl = w_q << 1;
  assign lo_w  = lo_q + w_q;
  assign lo_2w = lo_q + w_dbl;
  assign mid_n = (lo_w > cnt_q)  ? cnt_q : lo_w;
  assign hi_n  = (lo_2w > cnt_q) ? cnt_q : lo_2w;

  // shared compare unit: head of left run against head of right run
  assign a_live    = (a_q < mid_q);
  assign b_live    = (b_q < hi_q);
  assign take_a    = a_live && (!b_live || (rdata_a_i < rdata_b_i));
  assign k_next    = k_q + ONE_P;
  assign run_done  = (k_next == hi_q);
  assign pass_done = (lo_2w >= cnt_q);
  assign sort_done = (w_dbl >= cnt_q);

  // memory requests
  always_comb begin
    mem_ctl_o.rd_bank = src_q;
    if (state_q == ST_MERGE) begin
      mem_ctl_o.we      = 1'b1;
      mem_ctl_o.wr_bank = ~src_q;
      waddr_o           = k_q[AW-1:0];
      wdata_o           = take_a ? rdata_a_i : rdata_b_i;
    end else begin
      mem_ctl_o.we      = accept && room;
      mem_ctl_o.wr_bank = 1'b0;
      waddr_o           = cnt_q[AW-1:0];
      wdata_o           = in_key_i;
    end
    if (state_q == ST_READ || state_q == ST_MERGE) begin
      raddr_a_o = a_q[AW-1:0];
    end else begin
      raddr_a_o = idx_q[AW-1:0];
    end
    raddr_b_o = b_q[AW-1:0];
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = ((idx_q + ONE_P) == cnt_q);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      w_q         <= '0;
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      k_q         <= '0;
      idx_q       <= '0;
      src_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            cnt_q <= cnt_inc;
            if (in_final_i) begin
              src_q <= 1'b0;
              w_q   <= ONE_P;
              lo_q  <= '0;
              idx_q <= '0;
              state_q <= (cnt_inc <= ONE_P) ? ST_OUT_READ : ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          mid_q   <= mid_n;
          hi_q    <= hi_n;
          a_q     <= lo_q;
          b_q     <= mid_n;
          k_q     <= lo_q;
          state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_MERGE;
        end
        ST_MERGE: begin
          if (take_a) begin
            a_q <= a_q + ONE_P;
          end else begin
            b_q <= b_q + ONE_P;
          end
          k_q <= k_next;
          if (run_done) begin
            if (pass_done) begin
              src_q <= ~src_q;
              w_q   <= w_dbl;
              lo_q  <= '0;
              idx_q <= '0;
              state_q <= sort_done ? ST_OUT_READ : ST_SETUP;
            end else begin
              lo_q    <= lo_2w;
              state_q <= ST_SETUP;
            end
          end else begin
            state_q <= ST_READ;
          end
        end
        ST_OUT_READ: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT_SHOW;
        end
        ST_OUT_SHOW: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (out_last_o) begin
              cnt_q   <= '0;
              state_q <= ST_LOAD;
            end else begin
              idx_q   <= idx_q + ONE_P;
              state_q <= ST_OUT_READ;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/merge_sorter.sv @@
// ----------------------------------------------------------------------------
// merge_sorter
// Collects signed keys into a set, sorts it ascending by bottom-up merge
// sort and emits it with the largest key flagged.
// Load: one key per cycle while ready; the final key starts the sort.
// Sort: for n keys, ceil(log2 n) passes; each merged key is read (registered)
// from the source bank, then chosen by the single compare unit.
// Output: each key is read from the bank, then held valid until the sink takes it.
// Reset (async, active low) empties the set; memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sorter #(
  parameter int unsigned CAPACITY = ms_pkg::CAPACITY_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ms_key_if.sink        in_i,
  ms_sorted_if.source   out_o
);
  import ms_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  mem_ctl_t        mem_ctl;
  logic [AW-1:0]   waddr, raddr_a, raddr_b;
  key_t            wdata;
  key_t            rd_a [2];
  key_t            rd_b [2];
  key_t            rdata_a, rdata_b;

  // sequencer and compare unit
  ms_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_key_i    (in_i.key),
    .in_final_i  (in_i.final_req),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_last_o  (out_o.end_of_run),
    .mem_ctl_o   (mem_ctl),
    .waddr_o     (waddr),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .wdata_o     (wdata),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b)
  );

  // ping-pong banks: one is read while the other takes the merged run
  for (genvar g = 0; g < 2; g++) begin : g_bank
    ms_bank #(
      .DEPTH (CAPACITY)
    ) u_bank (
      .clk_i     (clk_i),
      .we_i      (mem_ctl.we && (mem_ctl.wr_bank == 1'(g))),
      .waddr_i   (waddr),
      .wdata_i   (wdata),
      .raddr_a_i (raddr_a),
      .raddr_b_i (raddr_b),
      .rdata_a_o (rd_a[g]),
      .rdata_b_o (rd_b[g])
    );
  end

  // source bank read data
  assign rdata_a = rd_a[mem_ctl.rd_bank];
  assign rdata_b = rd_b[mem_ctl.rd_bank];

  assign out_o.sorted_key = rdata_a;

endmodule

`default_nettype wire

@@ rtl/merge_sorter_checker.sv @@
// ----------------------------------------------------------------------------
// merge_sorter_checker
// Port-level checks of the merge sorter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sorter_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_i,
  input wire logic          in_final_i,
  input wire logic          out_valid_i,
  input wire logic          out_ready_i,
  input wire ms_pkg::key_t  out_key_i,
  input wire logic          out_last_i
);

  // a closing transaction stops intake
  a_final_stops_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_final_i) |=> !in_ready_i)
    else $error("input still ready after closing transaction");

  // intake and output never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && in_ready_i))
    else $error("output valid while input ready");

  // last result returns the block to loading
  a_last_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> (in_ready_i && !out_valid_i))
    else $error("block not ready for a new set after last result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_key_i) && $stable(out_last_i)))
    else $error("stalled result changed");

endmodule

bind merge_sorter merge_sorter_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_final_i  (in_i.final_req),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_key_i   (out_o.sorted_key),
  .out_last_i  (out_o.end_of_run)
);

`default_nettype wire
